### design/dffltr_pkg.sv
`timescale 1ns / 1ps
// Package for the forward frame filter: codes, widths and shared structs.
// Used by the interfaces and by every module of the block; depends on nothing.
package dffltr_pkg;

    localparam int TIME_WIDTH_DEFAULT = 32;
    localparam int MAX_SHORT_ADDRESS  = 63;

    localparam int CODE_W  = 9;
    localparam int BYTE_W  = 8;
    localparam int ADDR_W  = 7;
    localparam int GROUP_W = 16;
    localparam int WIN_W   = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] ADDR_BROADCAST_MASK = 8'hfe;
    localparam logic [BYTE_W-1:0] ADDR_GROUP_BIT_MASK = 8'h80;
    localparam logic [BYTE_W-1:0] ADDR_SPECIAL_MASK   = 8'h60;
    localparam logic [BYTE_W-1:0] ADDR_INITIALISE     = 8'ha5;
    localparam logic [BYTE_W-1:0] DATA_ALL            = 8'hff;
    localparam logic [BYTE_W-1:0] DATA_NONE           = 8'h00;
    localparam logic [BYTE_W-1:0] PARAM_INDEXED       = 8'hff;
    localparam logic [BYTE_W-1:0] COUNT_MAX           = 8'hff;
    localparam logic [CODE_W-1:0] CODE_DIRECT_POWER   = 9'h100;

    localparam logic [ADDR_W-1:0]  OWN_ADDR_RESET     = 7'd127;
    localparam logic [GROUP_W-1:0] GROUP_RESET        = 16'd0;
    localparam logic [WIN_W-1:0]   WINDOW_RESET       = 16'd100;

    typedef enum logic [1:0] {
        OP_FRAME = 2'd0,
        OP_REPLY = 2'd1,
        OP_BUS   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        EV_HANDLE   = 2'd0,
        EV_IGNORED  = 2'd1,
        EV_BUS_DISC = 2'd2
    } event_t;

    typedef enum logic [1:0] {
        BUS_UNKNOWN      = 2'd0,
        BUS_DISCONNECTED = 2'd1,
        BUS_CONNECTED    = 2'd2,
        BUS_OTHER        = 2'd3
    } bus_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OWN_ADDRESS = 2'd0,
        CFG_GROUPS      = 2'd1,
        CFG_WINDOW      = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic              match;
        logic [CODE_W-1:0] code;
        logic [BYTE_W-1:0] param;
    } decode_t;

    typedef struct packed {
        logic              valid;
        logic [1:0]        kind;
        logic [CODE_W-1:0] code;
        logic [BYTE_W-1:0] param;
        logic [BYTE_W-1:0] count;
    } result_t;

endpackage

### design/dffltr_if.sv
`timescale 1ns / 1ps
// Request and result channel interfaces of the forward frame filter.
// Depends on dffltr_pkg for the field widths.
interface dffltr_in_if
    import dffltr_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEFAULT
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            operation;
    logic [TIME_WIDTH-1:0] frame_time;
    logic [15:0]           frame_word;
    logic                  repeat_needed;
    logic [1:0]            bus_condition;

    modport source (
        output valid, operation, frame_time, frame_word, repeat_needed, bus_condition,
        input  ready
    );
    modport sink (
        input  valid, operation, frame_time, frame_word, repeat_needed, bus_condition,
        output ready
    );
endinterface

interface dffltr_out_if
    import dffltr_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [1:0]        event_kind;
    logic [CODE_W-1:0] command_code;
    logic [BYTE_W-1:0] command_param;
    logic [BYTE_W-1:0] repeat_count;

    modport source (
        output valid, event_kind, command_code, command_param, repeat_count,
        input  ready
    );
    modport sink (
        input  valid, event_kind, command_code, command_param, repeat_count,
        output ready
    );
endinterface

### design/dffltr_decode.sv
`timescale 1ns / 1ps
// Address decode of one forward frame: match test, command code and parameter.
// Depends on dffltr_pkg.
module dffltr_decode
    import dffltr_pkg::*;
(
    input  logic [15:0]        frame_word,
    input  logic [ADDR_W-1:0]  own_short_address,
    input  logic [GROUP_W-1:0] group_membership,
    output decode_t            dec
);

    logic [BYTE_W-1:0] abyte;
    logic [BYTE_W-1:0] dbyte;
    logic              broadcast;
    logic              plain_address;
    logic [3:0]        group_sel;
    logic              own_assigned;

    assign abyte = frame_word[15:8];
    assign dbyte = frame_word[7:0];
    assign broadcast = (abyte & ADDR_BROADCAST_MASK) == ADDR_BROADCAST_MASK;
    assign plain_address = broadcast || ((abyte & ADDR_GROUP_BIT_MASK) == '0)
                           || ((abyte & ADDR_SPECIAL_MASK) == '0);
    assign group_sel = abyte[4:1];
    assign own_assigned = own_short_address <= ADDR_W'(MAX_SHORT_ADDRESS);

    always_comb
    begin
        dec = '0;
        if (plain_address)
        begin
            if (broadcast)
                dec.match = 1'b1;
            else if (!abyte[7])
                dec.match = (abyte[7:1] == own_short_address);
            else
                dec.match = group_membership[group_sel];
            if (abyte[0])
            begin
                dec.code  = {1'b0, dbyte};
                dec.param = PARAM_INDEXED;
            end
            else
            begin
                dec.code  = CODE_DIRECT_POWER;
                dec.param = dbyte;
            end
        end
        else
        begin
            dec.match = 1'b1;
            if (abyte == ADDR_INITIALISE)
            begin
                if (dbyte == DATA_ALL)
                    dec.match = !own_assigned;
                else if (dbyte != DATA_NONE)
                    dec.match = (own_short_address == dbyte[7:1]);
            end
            dec.code  = {1'b1, abyte};
            dec.param = dbyte;
        end
    end

endmodule

### design/dffltr_core.sv
`timescale 1ns / 1ps
// Repeat tracking and bus state of the forward frame filter; one item per cycle while fire is high.
// Depends on dffltr_pkg and instantiates dffltr_decode.
module dffltr_core
    import dffltr_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  logic [1:0]            operation,
    input  logic [TIME_WIDTH-1:0] frame_time,
    input  logic [15:0]           frame_word,
    input  logic                  repeat_needed,
    input  logic [1:0]            bus_condition,
    input  logic [ADDR_W-1:0]     own_short_address,
    input  logic [GROUP_W-1:0]    group_membership,
    input  logic [WIN_W-1:0]      repeat_window,
    output result_t               res
);

    localparam int CMP_W = (TIME_WIDTH > WIN_W) ? TIME_WIDTH : WIN_W;

    decode_t               dec;
    logic [TIME_WIDTH-1:0] elapsed;
    logic                  in_window;

    logic                  armed_valid_reg, armed_valid_next;
    logic [CODE_W-1:0]     armed_command_reg, armed_command_next;
    logic [CODE_W-1:0]     pending_command_reg, pending_command_next;
    logic [BYTE_W-1:0]     repeat_counter_reg, repeat_counter_next;
    logic [TIME_WIDTH-1:0] last_frame_time_reg, last_frame_time_next;
    logic [1:0]            bus_condition_reg, bus_condition_next;

    dffltr_decode u_decode (
        .frame_word        (frame_word),
        .own_short_address (own_short_address),
        .group_membership  (group_membership),
        .dec               (dec)
    );

    assign elapsed   = frame_time - last_frame_time_reg;
    assign in_window = CMP_W'(elapsed) < CMP_W'(repeat_window);

    always_comb
    begin
        armed_valid_next     = armed_valid_reg;
        armed_command_next   = armed_command_reg;
        pending_command_next = pending_command_reg;
        repeat_counter_next  = repeat_counter_reg;
        last_frame_time_next = last_frame_time_reg;
        bus_condition_next   = bus_condition_reg;
        res = '0;
        unique case (operation)
            OP_FRAME:
            begin
                if (dec.match)
                begin
                    res.kind = EV_HANDLE;
                    if (!armed_valid_reg)
                        repeat_counter_next = '0;
                    else if (armed_command_reg == dec.code)
                    begin
                        if (!in_window)
                            repeat_counter_next = '0;
                        else if (repeat_counter_reg != COUNT_MAX)
                            repeat_counter_next = repeat_counter_reg + 1'b1;
                    end
                    else
                    begin
                        repeat_counter_next = '0;
                        if (in_window)
                            res.kind = EV_IGNORED;
                    end
                    last_frame_time_next = frame_time;
                    armed_valid_next = 1'b0;
                    if (res.kind == EV_HANDLE)
                        pending_command_next = dec.code;
                    res.valid = 1'b1;
                    res.code  = dec.code;
                    res.param = dec.param;
                    res.count = repeat_counter_next;
                end
            end
            OP_REPLY:
            begin
                armed_valid_next = repeat_needed;
                if (repeat_needed)
                    armed_command_next = pending_command_reg;
            end
            OP_BUS:
            begin
                if (bus_condition != bus_condition_reg)
                begin
                    bus_condition_next = bus_condition;
                    if (bus_condition == BUS_DISCONNECTED)
                    begin
                        res.valid = 1'b1;
                        res.kind  = EV_BUS_DISC;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_valid_reg     <= 1'b0;
            armed_command_reg   <= '0;
            pending_command_reg <= '0;
            repeat_counter_reg  <= '0;
            last_frame_time_reg <= '0;
            bus_condition_reg   <= BUS_UNKNOWN;
        end
        else if (fire)
        begin
            armed_valid_reg     <= armed_valid_next;
            armed_command_reg   <= armed_command_next;
            pending_command_reg <= pending_command_next;
            repeat_counter_reg  <= repeat_counter_next;
            last_frame_time_reg <= last_frame_time_next;
            bus_condition_reg   <= bus_condition_next;
        end
    end

endmodule

### design/dali_forward_frame_filter.sv
`timescale 1ns / 1ps
// Top level of the DALI forward frame filter: request register, configuration
// registers and result register around dffltr_core. Depends on dffltr_pkg and dffltr_if.
//
// A request is taken into an input register, processed by the address decode and repeat
// tracking logic once the output register can accept it, and its result, if any, lands
// in an output register. One request is accepted every cycle while results are taken;
// each request passes the input register and then the result register, even one with
// no result. Configuration is written through cfg_write, cfg_index and cfg_data; the
// user must write it only while idle, which the block itself does not enforce.
module dali_forward_frame_filter
    import dffltr_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    dffltr_in_if.sink            req,
    dffltr_out_if.source         rsp
);

    logic [ADDR_W-1:0]     own_short_address_reg;
    logic [GROUP_W-1:0]    group_membership_reg;
    logic [WIN_W-1:0]      repeat_window_reg;

    logic                  in_valid_reg;
    logic [1:0]            operation_reg;
    logic [TIME_WIDTH-1:0] frame_time_reg;
    logic [15:0]           frame_word_reg;
    logic                  repeat_needed_reg;
    logic [1:0]            bus_condition_in_reg;

    logic                  out_valid_reg;
    logic [1:0]            event_kind_reg;
    logic [CODE_W-1:0]     command_code_reg;
    logic [BYTE_W-1:0]     command_param_reg;
    logic [BYTE_W-1:0]     repeat_count_reg;

    logic                  advance;
    result_t               res;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_short_address_reg <= OWN_ADDR_RESET;
            group_membership_reg  <= GROUP_RESET;
            repeat_window_reg     <= WINDOW_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_OWN_ADDRESS: own_short_address_reg <= cfg_data[ADDR_W-1:0];
                CFG_GROUPS:      group_membership_reg  <= cfg_data[GROUP_W-1:0];
                CFG_WINDOW:      repeat_window_reg     <= cfg_data[WIN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (req.ready)
            in_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            operation_reg        <= req.operation;
            frame_time_reg       <= req.frame_time;
            frame_word_reg       <= req.frame_word;
            repeat_needed_reg    <= req.repeat_needed;
            bus_condition_in_reg <= req.bus_condition;
        end
    end

    dffltr_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .clk               (clk),
        .rst_n             (rst_n),
        .fire              (advance),
        .operation         (operation_reg),
        .frame_time        (frame_time_reg),
        .frame_word        (frame_word_reg),
        .repeat_needed     (repeat_needed_reg),
        .bus_condition     (bus_condition_in_reg),
        .own_short_address (own_short_address_reg),
        .group_membership  (group_membership_reg),
        .repeat_window     (repeat_window_reg),
        .res               (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= res.valid;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.valid)
        begin
            event_kind_reg    <= res.kind;
            command_code_reg  <= res.code;
            command_param_reg <= res.param;
            repeat_count_reg  <= res.count;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.event_kind    = event_kind_reg;
    assign rsp.command_code  = command_code_reg;
    assign rsp.command_param = command_param_reg;
    assign rsp.repeat_count  = repeat_count_reg;

endmodule
